// ----- hw/rtl/lbpp_pkg.sv -----
// lbpp_pkg: shared types and constants of the LFSR block pixel permuter.
// Used by lfsr_block_pixel_permuter and lbpp_checker; no dependencies.
`timescale 1ns / 1ps

package lbpp_pkg;

	// defaults for the top level parameters
	localparam int DEF_MAX_BLOCK  = 64;
	localparam int DEF_PIXEL_BITS = 32;

	// register field widths
	localparam int DEG_W     = 5;
	localparam int TAP_W     = 31;
	localparam int BLEN_W    = 7;
	localparam int ENTRY_W   = 7;
	localparam int CFG_IDX_W = 8;
	localparam int CFG_DAT_W = 31;

	// register reset values
	localparam logic [DEG_W-1:0]  DEGREE_RST = 5'd5;
	localparam logic [TAP_W-1:0]  TAPS_RST   = 31'd5;
	localparam logic [TAP_W-1:0]  SEED_RST   = 31'd1;
	localparam logic [BLEN_W-1:0] BLEN_RST   = 7'd16;

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEGREE = 8'd0,
		REG_TAPS   = 8'd1,
		REG_SEED   = 8'd2,
		REG_BLEN   = 8'd3
	} cfg_reg_t;

	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 8'd4;

	// sequencer states, one-hot
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MOD   = 8'b0000_0010,
		ST_RUN   = 8'b0000_0100,
		ST_SWBEG = 8'b0000_1000,
		ST_SWRD  = 8'b0001_0000,
		ST_SWWA  = 8'b0010_0000,
		ST_SWWB  = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

endpackage

// ----- hw/rtl/lfsr_block_pixel_permuter.sv -----
// lfsr_block_pixel_permuter: LFSR-keyed block permutation of a pixel stream.
// Depends on lbpp_pkg; table and block buffer are local synchronous memories.
`timescale 1ns / 1ps

//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data | in (write)
//  in      | in_valid in_ready pixel_in           | in
//  out     | out_valid out_ready pixel_out block_last | out
//
// An accepted pixel is written into the block buffer. When a block is full,
// the swap pass starts and walks the table: an entry that makes no swap just
// fetches the next one, and a swap reads both words, then writes each back
// through the single buffer write port; the emit pass then streams one beat
// per cycle while the output is not stalled. No new pixel is taken until
// the emit pass is done. The first pixel after reset or a register write
// builds the table first: seed reduction, then one LFSR step per cycle, at
// most 2^degree-1 steps, ending early when the table is full.
// Reset clears all control state; memories are not cleared.
// A stalled output holds its beat; the block keeps working until the next
// result needs the output register.

module lfsr_block_pixel_permuter
	import lbpp_pkg::*;
#(
	parameter int MAX_BLOCK  = DEF_MAX_BLOCK,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data,

	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PIXEL_BITS-1:0] pixel_in,

	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [PIXEL_BITS-1:0] pixel_out,
	output logic                  block_last
);

	localparam int IDXW = $clog2(MAX_BLOCK);      // buffer / table address
	localparam int LW   = $clog2(MAX_BLOCK + 1);  // counts up to MAX_BLOCK

	// configuration registers
	logic [DEG_W-1:0]  degree_q;
	logic [TAP_W-1:0]  taps_q;
	logic [TAP_W-1:0]  seed_q;
	logic [BLEN_W-1:0] blen_q;

	// control state
	state_t            state_q, state_d;
	logic              table_ready_q;
	logic [LW-1:0]     table_len_q;
	logic [LW-1:0]     fill_q;
	logic [LW-1:0]     idx_q;
	logic [IDXW-1:0]   e_q;          // partner address of the current swap
	logic [TAP_W-1:0]  fold_q;       // seed reduction accumulator
	logic [TAP_W-1:0]  start_q;
	logic [TAP_W-1:0]  lfsr_q;
	logic [TAP_W-1:0]  steps_q;      // LFSR steps still allowed
	logic              rd_valid_q;   // emit read data waiting
	logic              rd_last_q;
	logic              out_valid_q;
	logic [PIXEL_BITS-1:0] pixel_out_q;
	logic              last_q;

	// memories
	logic [ENTRY_W-1:0]    perm_mem [MAX_BLOCK];
	logic [PIXEL_BITS-1:0] buf_mem  [MAX_BLOCK];
	logic [ENTRY_W-1:0]    perm_rd_q;
	logic [PIXEL_BITS-1:0] rd_a_q;
	logic [PIXEL_BITS-1:0] rd_b_q;

	// memory controls
	logic                  perm_re;
	logic [IDXW-1:0]       perm_raddr;
	logic                  perm_we;
	logic                  buf_we;
	logic [IDXW-1:0]       buf_waddr;
	logic [PIXEL_BITS-1:0] buf_wdata;
	logic                  rd_a_en;
	logic [IDXW-1:0]       rd_a_addr;
	logic                  rd_b_en;

	// handshakes
	logic cfg_fire, cfg_hit, in_fire, out_free, out_load;

	// LFSR datapath
	logic [DEG_W-1:0] deg_eff;
	logic [TAP_W-1:0] dmask;
	logic [TAP_W-1:0] topbit;
	logic [TAP_W-1:0] fold_hi;
	logic [TAP_W-1:0] fold_sum;
	logic             fold_done;
	logic [TAP_W-1:0] start_val;
	logic             fb;
	logic [TAP_W-1:0] lfsr_nxt;
	logic             qual;
	logic [LW-1:0]    len_inc;
	logic             build_stop;

	// swap / emit
	logic [ENTRY_W-1:0] e_dec;
	logic               e_ok;
	logic [LW-1:0]      idx_inc;
	logic               idx_last;
	logic               emit_move;
	logic               emit_issue;
	logic               emit_done;

	//----------------------------------------------------------------------
	// handshakes
	//----------------------------------------------------------------------
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = (state_q == ST_IDLE);
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_fire && (cfg_index < REG_COUNT);
	// a pending register write goes first; empty table needs the output slot
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid && table_ready_q &&
		((table_len_q != '0) || out_free);
	assign in_fire   = in_valid && in_ready;
	// output register takes a new beat: pass-through pixel or emitted word
	assign out_load  = ((state_q == ST_IDLE) && in_fire && (table_len_q == '0)) ||
		((state_q == ST_EMIT) && emit_move);

	assign out_valid  = out_valid_q;
	assign pixel_out  = pixel_out_q;
	assign block_last = last_q;

	//----------------------------------------------------------------------
	// LFSR and seed reduction
	//----------------------------------------------------------------------
	assign deg_eff = (degree_q < DEG_W'(2)) ? DEG_W'(2) : degree_q;
	assign dmask   = {TAP_W{1'b1}} >> (DEG_W'(TAP_W) - deg_eff);
	assign topbit  = (dmask >> 1) + TAP_W'(1);

	// x mod (2^d - 1): fold high part onto low part until it fits in d bits
	assign fold_hi   = fold_q >> deg_eff;
	assign fold_sum  = fold_hi + (fold_q & dmask);
	assign fold_done = (fold_hi == '0);
	assign start_val = ((fold_q == dmask) ? '0 : fold_q) + TAP_W'(1);

	assign fb       = ^(taps_q & dmask & lfsr_q);
	assign lfsr_nxt = (lfsr_q >> 1) | (fb ? topbit : '0);
	assign qual     = (lfsr_nxt <= TAP_W'(blen_q));
	assign len_inc  = table_len_q + LW'(1);
	assign build_stop = (qual && (len_inc == LW'(MAX_BLOCK))) ||
		(!qual && (table_len_q == '0) && (lfsr_nxt == start_q)) ||
		(steps_q == TAP_W'(1));
	assign perm_we = (state_q == ST_RUN) && qual;

	//----------------------------------------------------------------------
	// swap and emit helpers
	//----------------------------------------------------------------------
	assign e_dec    = perm_rd_q - ENTRY_W'(1);
	assign e_ok     = (perm_rd_q != '0) && (perm_rd_q <= ENTRY_W'(table_len_q));
	assign idx_inc  = idx_q + LW'(1);
	assign idx_last = (idx_inc == table_len_q);

	assign emit_move  = rd_valid_q && out_free;
	assign emit_issue = (idx_q != table_len_q) && (!rd_valid_q || emit_move);
	assign emit_done  = (idx_q == table_len_q) && (!rd_valid_q || emit_move);

	//----------------------------------------------------------------------
	// sequencer
	//----------------------------------------------------------------------
	always_comb begin
		state_d    = state_q;
		perm_re    = 1'b0;
		perm_raddr = idx_q[IDXW-1:0];
		buf_we     = 1'b0;
		buf_waddr  = idx_q[IDXW-1:0];
		buf_wdata  = rd_b_q;
		rd_a_en    = 1'b0;
		rd_a_addr  = idx_q[IDXW-1:0];
		rd_b_en    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!cfg_valid && in_valid && !table_ready_q) begin
					state_d = ST_MOD;
				end else if (in_fire && (table_len_q != '0)) begin
					buf_we    = 1'b1;
					buf_waddr = fill_q[IDXW-1:0];
					buf_wdata = pixel_in;
					if (fill_q + LW'(1) == table_len_q) begin
						state_d = ST_SWBEG;
					end
				end
			end
			ST_MOD: begin
				if (fold_done) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (build_stop) begin
					state_d = ST_IDLE;
				end
			end
			ST_SWBEG: begin
				perm_re = 1'b1;
				state_d = ST_SWRD;
			end
			ST_SWRD: begin
				if (e_ok) begin
					rd_a_en = 1'b1;
					rd_b_en = 1'b1;
					state_d = ST_SWWA;
				end else if (idx_last) begin
					state_d = ST_EMIT;
				end else begin
					perm_re    = 1'b1;
					perm_raddr = idx_inc[IDXW-1:0];
				end
			end
			ST_SWWA: begin
				// buf[i] <= buf[e-1]; fetch the next entry meanwhile
				buf_we    = 1'b1;
				buf_wdata = rd_b_q;
				if (!idx_last) begin
					perm_re    = 1'b1;
					perm_raddr = idx_inc[IDXW-1:0];
				end
				state_d = ST_SWWB;
			end
			ST_SWWB: begin
				// buf[e-1] <= old buf[i]
				buf_we    = 1'b1;
				buf_waddr = e_q;
				buf_wdata = rd_a_q;
				state_d   = idx_last ? ST_EMIT : ST_SWRD;
			end
			ST_EMIT: begin
				rd_a_en = emit_issue;
				if (emit_done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			degree_q      <= DEGREE_RST;
			taps_q        <= TAPS_RST;
			seed_q        <= SEED_RST;
			blen_q        <= BLEN_RST;
			table_ready_q <= 1'b0;
			table_len_q   <= '0;
			fill_q        <= '0;
			idx_q         <= '0;
			e_q           <= '0;
			fold_q        <= '0;
			start_q       <= '0;
			lfsr_q        <= '0;
			steps_q       <= '0;
			rd_valid_q    <= 1'b0;
			rd_last_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			pixel_out_q   <= '0;
			last_q        <= 1'b0;
		end else begin
			state_q <= state_d;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_fire) begin
				unique case (cfg_index)
					REG_DEGREE: degree_q <= cfg_data[DEG_W-1:0];
					REG_TAPS:   taps_q   <= cfg_data[TAP_W-1:0];
					REG_SEED:   seed_q   <= cfg_data[TAP_W-1:0];
					REG_BLEN:   blen_q   <= cfg_data[BLEN_W-1:0];
					default:    ;
				endcase
			end
			if (cfg_hit) begin
				table_ready_q <= 1'b0;
				fill_q        <= '0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (state_d == ST_MOD) begin
						fold_q <= seed_q;
					end
					if (in_fire) begin
						if (table_len_q == '0) begin
							// empty table: pass the pixel straight through
							pixel_out_q <= pixel_in;
							last_q      <= 1'b1;
						end else if (state_d == ST_SWBEG) begin
							fill_q <= '0;
							idx_q  <= '0;
						end else begin
							fill_q <= fill_q + LW'(1);
						end
					end
				end
				ST_MOD: begin
					if (fold_done) begin
						start_q     <= start_val;
						lfsr_q      <= start_val;
						steps_q     <= dmask;
						table_len_q <= '0;
					end else begin
						fold_q <= fold_sum;
					end
				end
				ST_RUN: begin
					lfsr_q  <= lfsr_nxt;
					steps_q <= steps_q - TAP_W'(1);
					if (qual) begin
						table_len_q <= len_inc;
					end
					if (build_stop) begin
						table_ready_q <= 1'b1;
					end
				end
				ST_SWBEG: ;
				ST_SWRD: begin
					if (e_ok) begin
						e_q <= e_dec[IDXW-1:0];
					end else begin
						idx_q <= idx_last ? '0 : idx_inc;
					end
				end
				ST_SWWA: ;
				ST_SWWB: begin
					idx_q <= idx_last ? '0 : idx_inc;
				end
				ST_EMIT: begin
					if (emit_issue) begin
						idx_q      <= idx_inc;
						rd_valid_q <= 1'b1;
						rd_last_q  <= idx_last;
					end else if (emit_move) begin
						rd_valid_q <= 1'b0;
					end
					if (emit_move) begin
						pixel_out_q <= rd_a_q;
						last_q      <= rd_last_q;
					end
				end
				default: ;
			endcase
		end
	end

	//----------------------------------------------------------------------
	// permutation table: one write port, one registered read port
	//----------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (perm_we) begin
			perm_mem[table_len_q[IDXW-1:0]] <= lfsr_nxt[ENTRY_W-1:0];
		end
		if (perm_re) begin
			perm_rd_q <= perm_mem[perm_raddr];
		end
	end

	//----------------------------------------------------------------------
	// block buffer: one write port, two registered read ports
	//----------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_mem[buf_waddr] <= buf_wdata;
		end
		if (rd_a_en) begin
			rd_a_q <= buf_mem[rd_a_addr];
		end
		if (rd_b_en) begin
			rd_b_q <= buf_mem[e_dec[IDXW-1:0]];
		end
	end

endmodule

// ----- hw/rtl/lbpp_checker.sv -----
// lbpp_port_checker: port-level assertions for lfsr_block_pixel_permuter.
// Depends on lbpp_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps

module lbpp_port_checker
	import lbpp_pkg::*;
#(
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [PIXEL_BITS-1:0] pixel_out,
	input logic                  block_last
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(block_last))
		else $error("result beat changed while stalled");

	// register writes and pixel beats never share an edge
	a_cfg_in_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cfg_valid && cfg_ready && in_valid && in_ready))
		else $error("register write and pixel beat in the same cycle");

	// a valid register write forces a table rebuild before the next pixel
	a_cfg_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index < REG_COUNT) |=> !in_ready)
		else $error("pixel taken right after a register write");

endmodule

bind lfsr_block_pixel_permuter lbpp_port_checker #(.PIXEL_BITS(PIXEL_BITS)) u_lbpp_checker (.*);

// ----- tb/lbpp_checker.sv -----
// lbpp_checker: scoreboard for the LFSR block pixel permuter.
// Watches the cfg, in and out channels and predicts every output beat; uses lbpp_pkg.
`timescale 1ns / 1ps

module lbpp_checker
	import lbpp_pkg::*;
#(
	parameter int MAX_BLOCK  = DEF_MAX_BLOCK,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DAT_W-1:0]  cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [PIXEL_BITS-1:0] pixel_in,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [PIXEL_BITS-1:0] pixel_out,
	input  logic                  block_last,
	output int                    mismatches,
	output int                    outstanding
);

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pixel;
		logic                  last;
	} beat_t;

	// shadow registers
	logic [DEG_W-1:0]  degree_q = DEGREE_RST;
	logic [TAP_W-1:0]  taps_q   = TAPS_RST;
	logic [TAP_W-1:0]  seed_q   = SEED_RST;
	logic [BLEN_W-1:0] blen_q   = BLEN_RST;

	// predicted key and block contents
	logic [ENTRY_W-1:0]    key [MAX_BLOCK];
	int                    key_len   = 0;
	bit                    key_built = 1'b0;
	logic [PIXEL_BITS-1:0] block_buf [MAX_BLOCK];
	int                    fill      = 0;

	beat_t owed_beats [$];
	int    mismatch_total = 0;
	int    beats_seen     = 0;

	task automatic flag_mismatch(input string msg);
		mismatch_total++;
		$display("MISMATCH @%0t beat %0d: %s", $time, beats_seen, msg);
	endtask

	// queue one predicted output beat at the tail
	function automatic void owe_beat(input logic [PIXEL_BITS-1:0] px, input logic lst);
		beat_t b;
		b.pixel = px;
		b.last  = lst;
		owed_beats.insert(owed_beats.size(), b);
	endfunction

	function automatic void build_key();
		int unsigned       deg;
		longint unsigned   period;
		longint unsigned   stepno;
		logic [TAP_W-1:0]  taps;
		logic [TAP_W-1:0]  start;
		logic [TAP_W-1:0]  lfsr;
		logic              fb;
		deg    = (degree_q < 2) ? 2 : degree_q;
		period = (64'd1 << deg) - 64'd1;
		taps   = taps_q & TAP_W'(period);
		start  = TAP_W'(seed_q % period + 64'd1);
		lfsr   = start;
		key_len = 0;
		for (stepno = 0; stepno < period; stepno++) begin
			fb   = ^(taps & lfsr);
			lfsr = (lfsr >> 1) | (TAP_W'(fb) << (deg - 1));
			if (lfsr <= TAP_W'(blen_q)) begin
				key[key_len] = lfsr[ENTRY_W-1:0];
				key_len++;
				if (key_len >= MAX_BLOCK)
					break;
			end
			if (lfsr == start && key_len == 0)
				break;
		end
		key_built = 1'b1;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DAT_W-1:0] data);
		case (idx)
			REG_DEGREE: degree_q = data[DEG_W-1:0];
			REG_TAPS:   taps_q   = data[TAP_W-1:0];
			REG_SEED:   seed_q   = data[TAP_W-1:0];
			REG_BLEN:   blen_q   = data[BLEN_W-1:0];
			default:    return;
		endcase
		key_built = 1'b0;
		fill      = 0;
	endfunction

	function automatic void permute_pixel(input logic [PIXEL_BITS-1:0] px);
		int                    i;
		int                    e;
		logic [PIXEL_BITS-1:0] t;
		if (!key_built)
			build_key();
		// no key: pixels pass straight through, each one its own block
		if (key_len == 0) begin
			owe_beat(px, 1'b1);
			return;
		end
		block_buf[fill] = px;
		fill++;
		if (fill < key_len)
			return;
		for (i = 0; i < key_len; i++) begin
			e = key[i];
			if (e >= 1 && e <= key_len) begin
				t = block_buf[i];
				block_buf[i] = block_buf[e-1];
				block_buf[e-1] = t;
			end
		end
		for (i = 0; i < key_len; i++)
			owe_beat(block_buf[i], (i == key_len - 1));
		fill = 0;
	endfunction

	always @(posedge clk) begin : watch
		beat_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				apply_register(cfg_index, cfg_data);
			if (in_valid && in_ready)
				permute_pixel(pixel_in);
			if (out_valid && out_ready) begin
				if (owed_beats.size() == 0) begin
					flag_mismatch($sformatf("unexpected beat pixel_out=%h block_last=%b",
						pixel_out, block_last));
				end else begin
					want = owed_beats.pop_front();
					if (pixel_out !== want.pixel)
						flag_mismatch($sformatf("pixel_out=%h, want %h", pixel_out, want.pixel));
					if (block_last !== want.last)
						flag_mismatch($sformatf("block_last=%b, want %b", block_last, want.last));
				end
				beats_seen++;
			end
		end
		mismatches  <= mismatch_total;
		outstanding <= owed_beats.size();
	end

endmodule

// ----- tb/tb_lfsr_block_pixel_permuter.sv -----
// tb_lfsr_block_pixel_permuter: stimulus and verdict for the pixel permuter.
// Instantiates lfsr_block_pixel_permuter and lbpp_checker; uses lbpp_pkg.
`timescale 1ns / 1ps

module tb_lfsr_block_pixel_permuter;
	import lbpp_pkg::*;

	// Quiet time before a register write or the verdict: covers a whole table
	// build of the slowest key used here (degree 10, 1023 steps) plus the seed
	// reduction, with margin.
	localparam int QUIET_CYCLES  = 1200;
	// Long receiver hold-off, enough to fill the block and back up the input.
	localparam int HOLD_CYCLES   = 300;
	// Pixels offered after the directed part.
	localparam int RANDOM_PIXELS = 250;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index = '0;
	logic [CFG_DAT_W-1:0]      cfg_data  = '0;
	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	logic [DEF_PIXEL_BITS-1:0] pixel_in  = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [DEF_PIXEL_BITS-1:0] pixel_out;
	logic                      block_last;

	int mismatches;
	int outstanding;

	// idling knobs, percent of cycles
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	// raised by the stimulus, dropped by the receiver once its hold-off is done
	bit hold_req = 1'b0;

	lfsr_block_pixel_permuter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_in   (pixel_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.block_last (block_last)
	);

	lbpp_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_in    (pixel_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_out   (pixel_out),
		.block_last  (block_last),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs or loses beats.
	initial begin
		#20_000_000;
		$display("Some tests failed");
		$finish;
	end

	// Receiver: random stalls, or one long hold-off when asked for. At most one
	// assignment to out_ready per edge.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Four idling mixes, rotated phase by phase.
	task automatic set_idling(input int phase);
		case (phase % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
			default: begin send_idle_pct = 35; recv_stall_pct = 35; end
		endcase
	endtask

	// Wait until no beat is owed, then let any table build run out.
	// The first edge lets the checker's count catch up with the last beat.
	task automatic settle();
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write, so a
	// back-to-back write never lowers and raises it in one step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Full register set. Unused upper data bits are random; they must be ignored.
	task automatic write_config(input logic [DEG_W-1:0] deg, input logic [TAP_W-1:0] taps,
		input logic [TAP_W-1:0] seed, input logic [BLEN_W-1:0] blen);
		logic [CFG_DAT_W-1:0] word;
		settle();
		// now and then a write to an unmapped index, which changes nothing
		if ($urandom_range(3) == 0)
			write_reg(CFG_IDX_W'($urandom_range(255, REG_COUNT)), CFG_DAT_W'($urandom));
		word = CFG_DAT_W'($urandom);
		word[DEG_W-1:0] = deg;
		write_reg(REG_DEGREE, word);
		write_reg(REG_TAPS, taps);
		write_reg(REG_SEED, seed);
		word = CFG_DAT_W'($urandom);
		word[BLEN_W-1:0] = blen;
		write_reg(REG_BLEN, word);
		cfg_valid <= 1'b0;
	endtask

	// Offer one pixel beat, with a random gap ahead of it. With no gap, valid
	// simply stays high from the previous beat.
	task automatic send_pixel(input logic [DEF_PIXEL_BITS-1:0] px);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		pixel_in <= px;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic [DEF_PIXEL_BITS-1:0] rand_pixel();
		case ($urandom_range(9))
			0:       return '0;
			1:       return '1;
			default: return DEF_PIXEL_BITS'($urandom);
		endcase
	endfunction

	task automatic run_pixels(input int count);
		repeat (count) send_pixel(rand_pixel());
		in_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int          sent;
		int          phase;
		int          kind;
		int          count;
		int unsigned lowmask;
		logic [DEG_W-1:0]  deg;
		logic [TAP_W-1:0]  taps;
		logic [BLEN_W-1:0] blen;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// Reset key (degree 5, taps 5, seed 1, length 16): one full block with
		// the extreme words up front.
		send_pixel('0);
		send_pixel('1);
		send_pixel(32'hAAAA_AAAA);
		send_pixel(32'h5555_5555);
		send_pixel(32'h0000_0001);
		send_pixel(32'h8000_0000);
		run_pixels(10);

		// Degree zero is taken as two; block length zero leaves the key empty,
		// so every pixel comes straight back marked last.
		write_config(5'd0, 31'd3, 31'h7FFF_FFFF, 7'd0);
		run_pixels(3);

		// Degree one (also two), taps above the degree ignored, length 127:
		// three entries. Leave a partial block, poke two unmapped registers
		// (no effect), then a seed write throws the partial block away.
		write_config(5'd1, 31'h7FFF_FFFF, 31'd5, 7'd127);
		run_pixels(2);
		settle();
		write_reg(REG_COUNT, CFG_DAT_W'($urandom));
		write_reg(CFG_IDX_W'(8'hFF), CFG_DAT_W'($urandom));
		write_reg(REG_SEED, 31'd0);
		cfg_valid <= 1'b0;
		run_pixels(3);

		// --- random ---
		// Back-pressure: reset key again, receiver holds off long enough for the
		// block to fill and stall its input while the sender keeps offering.
		write_config(DEGREE_RST, TAPS_RST, SEED_RST, BLEN_RST);
		set_idling(0);
		hold_req = 1'b1;
		run_pixels(40);
		sent = 40;

		// Widest register: degree 31, no taps in range. The state shifts down to
		// zero and the key fills with 64 zero entries, none of which swaps.
		phase = 1;
		set_idling(phase);
		write_config(5'd31, 31'd0, 31'h7FFF_FFFF, 7'd64);
		run_pixels(70);
		sent += 70;

		// Degree 7 at length 127: usually more qualifying states than fit.
		phase++;
		set_idling(phase);
		write_config(5'd7, TAP_W'($urandom), TAP_W'($urandom), 7'd127);
		run_pixels(70);
		sent += 70;

		while (sent < RANDOM_PIXELS) begin
			phase++;
			set_idling(phase);
			kind = $urandom_range(99);
			blen = $urandom_range(1) ? BLEN_W'($urandom_range(20)) : BLEN_W'($urandom_range(127));
			if (kind < 65) begin
				// short keys, any taps: build is at most 255 steps
				deg   = DEG_W'($urandom_range(8));
				taps  = TAP_W'($urandom);
				count = $urandom_range(40, 6);
			end else if (kind < 85) begin
				deg   = DEG_W'($urandom_range(10, 9));
				taps  = TAP_W'($urandom);
				count = $urandom_range(40, 6);
			end else begin
				// long registers only with no taps in range, so the build ends
				// fast on a full key
				deg     = DEG_W'($urandom_range(31, 11));
				lowmask = (32'h1 << deg) - 32'h1;
				taps    = TAP_W'($urandom & ~lowmask);
				count   = $urandom_range(100, 64);
			end
			write_config(deg, taps, TAP_W'($urandom), blen);
			run_pixels(count);
			sent += count;
		end

		settle();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- lfsr_block_pixel_permuter.f -----
hw/rtl/lbpp_pkg.sv
hw/rtl/lfsr_block_pixel_permuter.sv
hw/rtl/lbpp_checker.sv
tb/lbpp_checker.sv
tb/tb_lfsr_block_pixel_permuter.sv
